// File: hdl/ritp_pkg.sv
`default_nettype none

package ritp_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Digit value returned for characters that are not digits or letters.
  localparam logic [7:0] NOT_A_DIGIT = 8'hFF;

  // Bases the prefix logic selects.
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;

  // Configuration register indexes.
  localparam logic REG_RADIX = 1'b0;
  localparam logic REG_CLAMP = 1'b1;

  localparam int CONSUMED_WIDTH = 16;

  // One input character with its start-of-string flag.
  typedef struct packed {
    logic       first;
    logic [7:0] ch;
  } item_t;

  // One parse result.
  typedef struct packed {
    logic [CONSUMED_WIDTH-1:0] consumed;
    logic signed [63:0]        value;
  } result_t;

  // Value of a digit or letter, NOT_A_DIGIT for anything else.
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = NOT_A_DIGIT;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + 8'd10;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A + 8'd10;
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_FF || c == CH_VT;
  endfunction

endpackage

`default_nettype wire

// File: hdl/radix_integer_text_parser_unit.sv
// Path: an accepted character is held in the input register and stepped by the parser
// from there; a result it causes is registered on the master side as it is stepped.
// Throughput: one character per cycle, set by the single 64-bit multiply-add of the
// accumulator. A character that ends a string waits in the input register while an
// earlier result is still held unread, which stalls the slave side.
// Reset (synchronous, active high): parser idle, radix 10, clamping off, no result.
`default_nettype none

module radix_integer_text_parser_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  input  wire logic        s_tuser,   // [0] first
  // Master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [63:0] value, [79:64] consumed
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_wdata
);

  logic [5:0]        radix;
  logic              clamp_negative;
  ritp_pkg::item_t   s_item;
  ritp_pkg::item_t   item;
  logic              item_valid;
  logic              item_take;
  logic              res_valid;
  logic              out_room;
  ritp_pkg::result_t res;
  ritp_pkg::result_t m_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix          <= ritp_pkg::BASE_DEC;
      clamp_negative <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ritp_pkg::REG_RADIX: radix          <= cfg_wdata;
        ritp_pkg::REG_CLAMP: clamp_negative <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign s_item.ch    = s_tdata;
  assign s_item.first = s_tuser;

  ritp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  ritp_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .radix          (radix),
    .clamp_negative (clamp_negative),
    .item_valid     (item_valid),
    .item           (item),
    .out_room       (out_room),
    .item_take      (item_take),
    .res_valid      (res_valid),
    .res            (res)
  );

  ritp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_room  (out_room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = {m_res.consumed, m_res.value};

  // A new result never lands on a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_room)
    else $error("result produced while output register is full");

  // Results come only from a character the core actually takes.
  a_res_from_item: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (item_take && item_valid))
    else $error("result without a taken character");

  // The slave side only stalls while a character is held.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> item_valid)
    else $error("slave side stalled with empty input register");

  // Unsigned mode never presents a negative value.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (res_valid && clamp_negative) |-> !res.value[63])
    else $error("negative value in unsigned mode");

endmodule

`default_nettype wire

// File: hdl/ritp_in_stage.sv
`default_nettype none

module ritp_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire ritp_pkg::item_t s_item,
  input  wire logic           item_take,
  output logic                item_valid,
  output ritp_pkg::item_t     item
);

  // The holding register frees up in the same cycle the core takes its item.
  assign s_tready = !item_valid || item_take;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Payload loads on every accepted transaction.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ritp_core.sv
`default_nettype none

module ritp_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [5:0]       radix,
  input  wire logic             clamp_negative,
  input  wire logic             item_valid,
  input  wire ritp_pkg::item_t  item,
  input  wire logic             out_room,
  output logic                  item_take,
  output logic                  res_valid,
  output ritp_pkg::result_t     res
);

  localparam int EXT_WIDTH = (COUNT_WIDTH > ritp_pkg::CONSUMED_WIDTH) ?
                             COUNT_WIDTH : ritp_pkg::CONSUMED_WIDTH;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_PREFIX,
    PH_ZERO,
    PH_AFTER_X,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                   phase, phase_next;
  logic [63:0]              acc, acc_next;
  logic                     neg, neg_next;
  logic [5:0]               base, base_next;
  logic [COUNT_WIDTH-1:0]   cnt, cnt_next;
  logic                     stop;
  logic                     emit;
  logic [63:0]              emit_val;
  logic [COUNT_WIDTH-1:0]   emit_cnt;
  logic [7:0]               dig;
  logic [EXT_WIDTH-1:0]     cnt_ext;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  assign dig = ritp_pkg::digit_of(item.ch);

  // One character step: the phases fall through as the prefix resolves.
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    base_next  = base;
    cnt_next   = cnt;
    stop       = 1'b0;
    emit       = 1'b0;
    emit_val   = '0;
    emit_cnt   = '0;

    if (item.first) begin
      phase_next = PH_SPACE;
      acc_next   = '0;
      neg_next   = 1'b0;
      base_next  = radix;
      cnt_next   = '0;
    end else if (phase == PH_IDLE || phase == PH_DONE) begin
      stop = 1'b1;
    end

    // Leading whitespace and the optional sign.
    if (!stop && phase_next == PH_SPACE) begin
      if (ritp_pkg::is_blank(item.ch)) begin
        cnt_next = sat_inc(cnt_next);
        stop     = 1'b1;
      end else begin
        phase_next = PH_PREFIX;
        if (item.ch == ritp_pkg::CH_PLUS || item.ch == ritp_pkg::CH_MINUS) begin
          neg_next = (item.ch == ritp_pkg::CH_MINUS);
          cnt_next = sat_inc(cnt_next);
          stop     = 1'b1;
        end
      end
    end

    // First character after the sign: a leading zero, the first digit or the end of the string.
    if (!stop && phase_next == PH_PREFIX) begin
      if ((base_next == ritp_pkg::BASE_AUTO || base_next == ritp_pkg::BASE_HEX) &&
          item.ch == ritp_pkg::CH_DIGIT_0) begin
        cnt_next   = sat_inc(cnt_next);
        phase_next = PH_ZERO;
      end else begin
        if (base_next == ritp_pkg::BASE_AUTO) begin
          base_next = ritp_pkg::BASE_DEC;
        end
        if (dig < {2'b00, base_next}) begin
          acc_next   = {56'd0, dig};
          cnt_next   = sat_inc(cnt_next);
          phase_next = PH_DIGITS;
        end else begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end
      end
      stop = 1'b1;
    end

    // After a leading zero: an x turns the base to hex, else the auto base becomes octal.
    if (!stop && phase_next == PH_ZERO) begin
      if (item.ch == ritp_pkg::CH_LOWER_X || item.ch == ritp_pkg::CH_UPPER_X) begin
        cnt_next   = sat_inc(cnt_next);
        base_next  = ritp_pkg::BASE_HEX;
        phase_next = PH_AFTER_X;
        stop       = 1'b1;
      end else begin
        if (base_next == ritp_pkg::BASE_AUTO) begin
          base_next = ritp_pkg::BASE_OCT;
        end
        phase_next = PH_DIGITS;
      end
    end

    // After 0x a hex digit must follow, else only the zero counts.
    if (!stop && phase_next == PH_AFTER_X) begin
      if (dig < 8'd16) begin
        acc_next   = {56'd0, dig};
        cnt_next   = sat_inc(cnt_next);
        phase_next = PH_DIGITS;
      end else begin
        emit       = 1'b1;
        emit_cnt   = cnt_next - COUNT_WIDTH'(1);
        phase_next = PH_DONE;
      end
      stop = 1'b1;
    end

    // Digit run: one multiply-add per character, wrapping at 64 bits.
    if (!stop) begin
      if (dig < {2'b00, base_next}) begin
        acc_next = 64'(acc_next * {58'd0, base_next}) + {56'd0, dig};
        cnt_next = sat_inc(cnt_next);
      end else begin
        emit       = 1'b1;
        emit_val   = neg_next ? (64'd0 - acc_next) : acc_next;
        emit_cnt   = cnt_next;
        phase_next = PH_DONE;
      end
    end
  end

  // A step that produces no result never waits on the output side.
  assign item_take = item_valid && (!emit || out_room);
  assign res_valid = item_take && emit;

  // Result fields: clamp in unsigned mode, saturate the count.
  assign cnt_ext   = EXT_WIDTH'(emit_cnt);
  assign res.value = (clamp_negative && emit_val[63]) ? 64'sd0 : $signed(emit_val);
  assign res.consumed =
    (cnt_ext > EXT_WIDTH'({ritp_pkg::CONSUMED_WIDTH{1'b1}})) ?
    {ritp_pkg::CONSUMED_WIDTH{1'b1}} : cnt_ext[ritp_pkg::CONSUMED_WIDTH-1:0];

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      acc   <= '0;
      neg   <= 1'b0;
      base  <= ritp_pkg::BASE_DEC;
      cnt   <= '0;
    end else if (item_take) begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      base  <= base_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ritp_out_stage.sv
`default_nettype none

module ritp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire ritp_pkg::result_t res,
  output logic                   out_room,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output ritp_pkg::result_t      m_res
);

  // The register can take a new result when empty or being emptied.
  assign out_room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_room) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_room) begin
      m_res <= res;
    end
  end

endmodule

`default_nettype wire

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES = 24;

  // Parser progress through one string, as the scoreboard tracks it.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_BLANKS,
    SCAN_LEAD,
    SCAN_ZERO,
    SCAN_HEX_START,
    SCAN_DIGITS,
    SCAN_DONE
  } scan_state_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [79:0] m_tdata;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = ritp_pkg::REG_RADIX;
  logic [5:0]  cfg_wdata = '0;

  // Characters waiting to be sent and parse results still owed by the block.
  ritp_pkg::item_t   chars_pending[$];
  ritp_pkg::result_t results_due[$];

  // Scoreboard copy of the registers and of the parser state.
  logic [5:0]  radix_setting = ritp_pkg::BASE_DEC;
  logic        clamp_setting = 1'b0;
  scan_state_t scan_state    = SCAN_IDLE;
  logic [63:0] magnitude     = '0;
  logic        minus_seen    = 1'b0;
  logic [5:0]  cur_base      = ritp_pkg::BASE_DEC;
  logic [15:0] char_total    = '0;

  int src_gap      = 0;
  int snk_gap      = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int errors       = 0;
  int cycle_count  = 0;

  radix_integer_text_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Digit value of a character; 255 for anything that is not a digit or letter.
  function automatic logic [7:0] char_value(input logic [7:0] c);
    if (c >= ritp_pkg::CH_DIGIT_0 && c <= ritp_pkg::CH_DIGIT_9) begin
      return c - ritp_pkg::CH_DIGIT_0;
    end
    if (c >= ritp_pkg::CH_LOWER_A && c <= ritp_pkg::CH_LOWER_Z) begin
      return c - ritp_pkg::CH_LOWER_A + 8'd10;
    end
    if (c >= ritp_pkg::CH_UPPER_A && c <= ritp_pkg::CH_UPPER_Z) begin
      return c - ritp_pkg::CH_UPPER_A + 8'd10;
    end
    return ritp_pkg::NOT_A_DIGIT;
  endfunction

  function automatic bit is_space_char(input logic [7:0] c);
    case (c)
      ritp_pkg::CH_SPACE, ritp_pkg::CH_TAB, ritp_pkg::CH_LF, ritp_pkg::CH_CR,
      ritp_pkg::CH_FF, ritp_pkg::CH_VT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void count_char();
    if (char_total != 16'hFFFF) begin
      char_total = char_total + 16'd1;
    end
  endfunction

  // Closes the string and builds its result, clamping negatives when enabled.
  function automatic ritp_pkg::result_t close_string(input logic [63:0] val,
                                                     input logic [15:0] cnt);
    ritp_pkg::result_t r;
    r.value    = (clamp_setting && val[63]) ? 64'd0 : val;
    r.consumed = cnt;
    scan_state = SCAN_DONE;
    return r;
  endfunction

  // Advances the scoreboard by one character; returns 1 when a result is due.
  function automatic bit parse_step(input logic [7:0] c, input logic lead,
                                    output ritp_pkg::result_t res);
    logic [7:0] dv;
    res = '0;
    if (lead) begin
      scan_state = SCAN_BLANKS;
      magnitude  = '0;
      minus_seen = 1'b0;
      cur_base   = radix_setting;
      char_total = '0;
    end else if (scan_state == SCAN_IDLE || scan_state == SCAN_DONE) begin
      return 1'b0;
    end
    dv = char_value(c);

    if (scan_state == SCAN_BLANKS) begin
      if (is_space_char(c)) begin
        count_char();
        return 1'b0;
      end
      scan_state = SCAN_LEAD;
      if (c == ritp_pkg::CH_PLUS || c == ritp_pkg::CH_MINUS) begin
        minus_seen = (c == ritp_pkg::CH_MINUS);
        count_char();
        return 1'b0;
      end
    end

    if (scan_state == SCAN_LEAD) begin
      if ((cur_base == ritp_pkg::BASE_AUTO || cur_base == ritp_pkg::BASE_HEX) &&
          c == ritp_pkg::CH_DIGIT_0) begin
        count_char();
        scan_state = SCAN_ZERO;
        return 1'b0;
      end
      if (cur_base == ritp_pkg::BASE_AUTO) begin
        cur_base = ritp_pkg::BASE_DEC;
      end
      if (dv < {2'b00, cur_base}) begin
        magnitude = 64'(dv);
        count_char();
        scan_state = SCAN_DIGITS;
        return 1'b0;
      end
      res = close_string(64'd0, 16'd0);
      return 1'b1;
    end

    // A zero after the sign may open a hex prefix or, in auto mode, octal.
    if (scan_state == SCAN_ZERO) begin
      if (c == ritp_pkg::CH_LOWER_X || c == ritp_pkg::CH_UPPER_X) begin
        count_char();
        cur_base   = ritp_pkg::BASE_HEX;
        scan_state = SCAN_HEX_START;
        return 1'b0;
      end
      if (cur_base == ritp_pkg::BASE_AUTO) begin
        cur_base = ritp_pkg::BASE_OCT;
      end
      scan_state = SCAN_DIGITS;
    end

    // Without a hex digit after the prefix only the zero counts as parsed.
    if (scan_state == SCAN_HEX_START) begin
      if (dv < 8'd16) begin
        magnitude = 64'(dv);
        count_char();
        scan_state = SCAN_DIGITS;
        return 1'b0;
      end
      res = close_string(64'd0, char_total - 16'd1);
      return 1'b1;
    end

    if (dv < {2'b00, cur_base}) begin
      magnitude = magnitude * 64'(cur_base) + 64'(dv);
      count_char();
      return 1'b0;
    end
    res = close_string(minus_seen ? 64'd0 - magnitude : magnitude, char_total);
    return 1'b1;
  endfunction

  // Sender: predicts every accepted transaction, then offers the next character.
  always @(posedge clk) begin : drive_chars
    ritp_pkg::result_t res;
    ritp_pkg::item_t   nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (parse_step(s_tdata, s_tuser, res)) begin
          results_due.push_back(res);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
          src_gap = $urandom_range(16);
          s_tvalid <= 1'b0;
        end else if (chars_pending.size() != 0) begin
          nxt = chars_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.ch;
          s_tuser  <= nxt.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    ritp_pkg::result_t got;
    ritp_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %h consumed %0d",
                 $time, got.value, got.consumed);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value mismatch, expected %h, actual %h",
                   $time, want.value, got.value);
          errors++;
        end
        if (got.consumed !== want.consumed) begin
          $display("%0t: consumed mismatch, expected %0d, actual %0d",
                   $time, want.consumed, got.consumed);
          errors++;
        end
      end
    end
    if (snk_gap > 0) begin
      snk_gap--;
      m_tready <= 1'b0;
    end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
      snk_gap = $urandom_range(16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL radix_integer_text_parser_unit");
      $finish;
    end
  end

  function automatic void push_char(input logic [7:0] c, input logic lead);
    ritp_pkg::item_t it;
    it.first = lead;
    it.ch    = c;
    chars_pending.push_back(it);
  endfunction

  function automatic void push_text(input string s, input logic lead);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], lead && i == 0);
    end
  endfunction

  function automatic logic [7:0] blank_char(input int k);
    case (k)
      0: return ritp_pkg::CH_SPACE;
      1: return ritp_pkg::CH_TAB;
      2: return ritp_pkg::CH_LF;
      3: return ritp_pkg::CH_CR;
      4: return ritp_pkg::CH_FF;
      default: return ritp_pkg::CH_VT;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(input int d, input bit upper);
    if (d < 10) begin
      return ritp_pkg::CH_DIGIT_0 + 8'(d);
    end
    return (upper ? ritp_pkg::CH_UPPER_A : ritp_pkg::CH_LOWER_A) + 8'(d - 10);
  endfunction

  function automatic int idle_pct(input int k);
    case (k)
      0: return 0;
      1: return 4;
      2: return 12;
      default: return 35;
    endcase
  endfunction

  // One number string with random blanks, sign, prefix and digits for this radix,
  // ended by NUL, by a stray character, or cut off by the next string.
  function automatic void push_number(input logic [5:0] rdx);
    logic [7:0] txt[$];
    int eff_base;
    int ndig;
    int pick;
    int d;
    bit cut_off;
    if ($urandom_range(9) < 3) begin
      repeat ($urandom_range(1, 3)) txt.push_back(blank_char($urandom_range(5)));
    end
    pick = $urandom_range(3);
    if (pick == 1) begin
      txt.push_back(ritp_pkg::CH_PLUS);
    end else if (pick == 2) begin
      txt.push_back(ritp_pkg::CH_MINUS);
    end
    eff_base = (rdx == ritp_pkg::BASE_AUTO) ? 10 : int'(rdx);
    pick = $urandom_range(5);
    if (pick == 1 || pick == 2) begin
      txt.push_back(ritp_pkg::CH_DIGIT_0);
      txt.push_back(pick == 1 ? ritp_pkg::CH_LOWER_X : ritp_pkg::CH_UPPER_X);
      if (rdx == ritp_pkg::BASE_AUTO || rdx == ritp_pkg::BASE_HEX) begin
        eff_base = 16;
      end
    end else if (pick == 3) begin
      txt.push_back(ritp_pkg::CH_DIGIT_0);
      if (rdx == ritp_pkg::BASE_AUTO) begin
        eff_base = 8;
      end
    end
    if (eff_base > 36) begin
      eff_base = 36;
    end
    ndig = ($urandom_range(9) == 0) ? $urandom_range(14, 25) : $urandom_range(8);
    repeat (ndig) begin
      d = ($urandom_range(15) == 0) ? $urandom_range(35) : $urandom_range(eff_base - 1);
      txt.push_back(digit_char(d, $urandom_range(1)));
    end
    pick = $urandom_range(9);
    cut_off = (pick == 9);
    if (pick < 7) begin
      txt.push_back(ritp_pkg::CH_NUL);
    end else if (!cut_off) begin
      txt.push_back(8'($urandom_range(1, 255)));
    end else if (txt.size() == 0) begin
      txt.push_back(8'($urandom_range(255)));
    end
    if (!cut_off && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(255)));
    end
    foreach (txt[i]) begin
      push_char(txt[i], i == 0);
    end
  endfunction

  task automatic set_config(input logic [5:0] rdx, input logic clamp);
    cfg_we    <= 1'b1;
    cfg_index <= ritp_pkg::REG_RADIX;
    cfg_wdata <= rdx;
    @(posedge clk);
    cfg_index <= ritp_pkg::REG_CLAMP;
    cfg_wdata <= {5'($urandom), clamp};
    @(posedge clk);
    cfg_we <= 1'b0;
    radix_setting = rdx;
    clamp_setting = clamp;
  endtask

  // Waits until every character is accepted and every result has arrived.
  task automatic wait_idle();
    do @(negedge clk);
    while (chars_pending.size() != 0 || s_tvalid || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed strings with random content, some raw noise.
  task automatic random_phase(input logic [5:0] rdx, input logic clamp, input int n_chars,
                              input bit quiet);
    set_config(rdx, clamp);
    src_idle_pct = quiet ? 0 : idle_pct($urandom_range(3));
    snk_idle_pct = quiet ? 0 : idle_pct($urandom_range(3));
    while (chars_pending.size() < n_chars) begin
      if ($urandom_range(99) < 85) begin
        push_number(rdx);
      end else begin
        repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(255)), $urandom_range(5) == 0);
      end
    end
    wait_idle();
  endtask

  initial begin
    logic [5:0] radix_plan[10];
    radix_plan = '{ritp_pkg::BASE_HEX, 6'd36, 6'd63, 6'd1, 6'd2, ritp_pkg::BASE_AUTO,
                   6'd37, ritp_pkg::BASE_OCT, ritp_pkg::BASE_DEC, 6'($urandom)};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: ignored character before any string, blanks and sign,
    // a sign with no digits, a dropped string, and characters after the stop.
    src_idle_pct = 12;
    snk_idle_pct = 12;
    push_char("7", 1'b0);
    push_char(ritp_pkg::CH_VT, 1'b1);
    push_text("+4", 1'b0);
    push_char(ritp_pkg::CH_NUL, 1'b0);
    push_text("-", 1'b1);
    push_char(ritp_pkg::CH_NUL, 1'b0);
    push_text("1", 1'b1);
    push_text("-3", 1'b1);
    push_char(ritp_pkg::CH_NUL, 1'b0);
    push_text("5x9", 1'b1);
    wait_idle();

    // Auto base with clamping: bare hex prefix, octal zero, clamped negative.
    set_config(ritp_pkg::BASE_AUTO, 1'b1);
    push_text("0x", 1'b1);
    push_char(ritp_pkg::CH_NUL, 1'b0);
    push_text("08", 1'b1);
    push_text("-0X1f", 1'b1);
    push_char(ritp_pkg::CH_NUL, 1'b0);
    wait_idle();

    foreach (radix_plan[i]) begin
      random_phase(radix_plan[i], i % 2 == 0, 75, 1'b0);
    end

    random_phase(ritp_pkg::BASE_AUTO, 1'b1, 50, 1'b1);

    if (errors == 0) begin
      $display("PASS radix_integer_text_parser_unit");
    end else begin
      $display("FAIL radix_integer_text_parser_unit");
    end
    $finish;
  end

endmodule
